>>> hdl/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// condition implies consequence in the next cycle
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> hdl/bba_pkg.sv
// shared types, codes and helpers of the buddy block allocator
package bba_pkg;

  localparam int ORD_W     = 5;
  localparam int CW        = ORD_W + 1;
  localparam int OFF_W     = 20;
  localparam int REQ_W     = 21;
  localparam int HDR_W     = 7;
  localparam int TOT_W     = 22;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_POOL  = 20;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ORDER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_BYTES  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] address;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ALLOC_RO, ST_SCAN, ST_TAKE,
    ST_DROP_RD, ST_DROP_EV, ST_DROP_PW, ST_DROP_NRD, ST_DROP_NW,
    ST_PUSH_RD, ST_PUSH_W, ST_PUSH_HRD, ST_PUSH_HW,
    ST_SPLIT, ST_FIN_RD, ST_FIN_W,
    ST_FREE_CHK, ST_FREE_RD, ST_FREE_EV,
    ST_MERGE, ST_MERGE_EV, ST_MERGE_UP, ST_MERGE_W,
    ST_DONE
  } state_t;

  // smallest r with 2^r >= v
  function automatic logic [ORD_W-1:0] ceil_log2(input logic [TOT_W-1:0] v);
    logic [TOT_W-1:0] m;
    logic [ORD_W-1:0] r;
    m = v - TOT_W'(1);
    r = '0;
    if (v > TOT_W'(1)) begin
      for (int i = 0; i < TOT_W; i++) begin
        if (m[i]) r = ORD_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/bba_slot_mem.sv
// slot table memory, one write and one registered read port
module bba_slot_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bba_seq.sv
// command sequencer: free list heads and slot table read-modify-write
`include "assert_macros.svh"

module bba_seq #(
  parameter int ORDER_COUNT = 16,
  parameter int SLOT_COUNT  = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  bba_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_take,
  output bba_pkg::res_t                 res,
  input  logic [bba_pkg::ORD_W-1:0]     cfg_pool,
  input  logic [bba_pkg::ORD_W-1:0]     cfg_min,
  input  logic [bba_pkg::HDR_W-1:0]     cfg_hdr
);

  localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ORD_W = bba_pkg::ORD_W;
  localparam int CW = bba_pkg::CW;
  localparam int OFF_W = bba_pkg::OFF_W;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             free;
    logic [SW-1:0]    nxt;
    logic             nok;
    logic [SW-1:0]    prv;
    logic             pok;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // memory port
  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;
  logic [EW-1:0] mem_rbits;
  entry_t        rd;

  bba_slot_mem #(.DEPTH(SLOT_COUNT), .WIDTH(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rbits)
  );

  assign rd = entry_t'(mem_rbits);

  // state
  bba_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic                     active_r, active_nxt;
  logic [ORD_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [bba_pkg::HDR_W-1:0] hdr_r, hdr_nxt;
  logic [SW-1:0]            head_r [ORDER_COUNT];
  logic [SW-1:0]            head_nxt [ORDER_COUNT];
  logic [ORDER_COUNT-1:0]   hok_r, hok_nxt;
  logic [OW-1:0]            li_r, li_nxt;
  logic [SW-1:0]            s_r, s_nxt, cur_r, cur_nxt;
  entry_t                   e_r, e_nxt;
  logic [ORD_W-1:0]         ord_r, ord_nxt, t_r, t_nxt;
  logic [CW-1:0]            c_r, c_nxt;
  bba_pkg::cmd_t            cmd_r, cmd_nxt;
  bba_pkg::res_t            res_r, res_nxt;

  // helpers
  logic [ORD_W-1:0]          span, diff, ro, ord_lo, c_dec_ord;
  logic [CW-1:0]             c_dec;
  logic [bba_pkg::TOT_W-1:0] total;
  logic [OFF_W-1:0]          off, pay, lo_mask;
  logic                      cfg_bad, free_bad;
  logic [SW-1:0]             ord_bit, cur_up;

  assign span      = hi_r - lo_r;
  assign diff      = cfg_pool - cfg_min;
  assign total     = bba_pkg::TOT_W'(cmd_r.request_bytes) + bba_pkg::TOT_W'(hdr_r);
  assign c_dec     = c_r - CW'(1);
  assign c_dec_ord = ORD_W'(c_dec);
  assign ord_lo    = ord_r - lo_r;
  assign ord_bit   = SW'(1) << ord_lo;
  assign cur_up    = cur_r & ~ord_bit;
  assign pay       = cmd_r.payload_offset;
  assign off       = pay - OFF_W'(hdr_r);
  assign lo_mask   = (OFF_W'(1) << lo_r) - OFF_W'(1);

  always_comb begin
    ro = bba_pkg::ceil_log2(total);
    if (ro < lo_r) ro = lo_r;
  end

  assign cfg_bad = (cfg_min > cfg_pool) || (cfg_pool > ORD_W'(bba_pkg::MAX_POOL)) ||
                   (32'(diff) >= 32'(ORDER_COUNT)) ||
                   ((33'(1) << diff) > 33'(SLOT_COUNT));
  assign free_bad = (pay < OFF_W'(hdr_r)) || ((off >> hi_r) != '0) ||
                    ((off & lo_mask) != '0);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bba_pkg::ST_IDLE;
      ret_r    <= bba_pkg::ST_IDLE;
      active_r <= 1'b0;
      hok_r    <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
      hdr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      active_r <= active_nxt;
      hok_r    <= hok_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    li_r   <= li_nxt;
    s_r    <= s_nxt;
    cur_r  <= cur_nxt;
    e_r    <= e_nxt;
    ord_r  <= ord_nxt;
    t_r    <= t_nxt;
    c_r    <= c_nxt;
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    active_nxt = active_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    hdr_nxt    = hdr_r;
    head_nxt   = head_r;
    hok_nxt    = hok_r;
    li_nxt     = li_r;
    s_nxt      = s_r;
    cur_nxt    = cur_r;
    e_nxt      = e_r;
    ord_nxt    = ord_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    cmd_nxt    = cmd_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = s_r;
    mem_raddr  = s_r;
    mem_wdata  = rd;
    cmd_ready  = 1'b0;

    unique case (state_r)
      bba_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          res_nxt = '0;
          state_nxt = bba_pkg::ST_DONE;
          if (cmd.command == bba_pkg::CMD_INIT) begin
            active_nxt = 1'b0;
            hok_nxt    = '0;
            for (int i = 0; i < ORDER_COUNT; i++) head_nxt[i] = '0;
            if (!cfg_bad) begin
              lo_nxt     = cfg_min;
              hi_nxt     = cfg_pool;
              hdr_nxt    = cfg_hdr;
              active_nxt = 1'b1;
              li_nxt     = OW'(diff);
              s_nxt      = '0;
              ord_nxt    = cfg_pool;
              res_nxt.ok = 1'b1;
              ret_nxt    = bba_pkg::ST_DONE;
              state_nxt  = bba_pkg::ST_PUSH_RD;
            end
          end else if (cmd.command == bba_pkg::CMD_ALLOC && active_r) begin
            state_nxt = bba_pkg::ST_ALLOC_RO;
          end else if (cmd.command == bba_pkg::CMD_FREE && active_r) begin
            state_nxt = bba_pkg::ST_FREE_CHK;
          end
        end
      end

      // size rounding and first order to look at
      bba_pkg::ST_ALLOC_RO: begin
        if (ro > hi_r) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          t_nxt     = ro - lo_r;
          c_nxt     = CW'(ro - lo_r);
          state_nxt = bba_pkg::ST_SCAN;
        end
      end

      // one order per cycle up to the first non-empty list
      bba_pkg::ST_SCAN: begin
        if (c_r > CW'(span)) begin
          state_nxt = bba_pkg::ST_DONE;
        end else if (hok_r[c_r[OW-1:0]]) begin
          li_nxt    = c_r[OW-1:0];
          state_nxt = bba_pkg::ST_TAKE;
        end else begin
          c_nxt = c_r + CW'(1);
        end
      end

      bba_pkg::ST_TAKE: begin
        s_nxt     = head_r[li_r];
        cur_nxt   = head_r[li_r];
        ret_nxt   = bba_pkg::ST_SPLIT;
        state_nxt = bba_pkg::ST_DROP_RD;
      end

      // unlink slot s_r from list li_r
      bba_pkg::ST_DROP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = s_r;
        state_nxt = bba_pkg::ST_DROP_EV;
      end

      bba_pkg::ST_DROP_EV: begin
        e_nxt = rd;
        if (rd.pok) begin
          mem_re    = 1'b1;
          mem_raddr = rd.prv;
          state_nxt = bba_pkg::ST_DROP_PW;
        end else begin
          head_nxt[li_r] = rd.nxt;
          hok_nxt[li_r]  = rd.nok;
          if (rd.nok) begin
            mem_re    = 1'b1;
            mem_raddr = rd.nxt;
            state_nxt = bba_pkg::ST_DROP_NW;
          end else begin
            state_nxt = ret_r;
          end
        end
      end

      bba_pkg::ST_DROP_PW: begin
        mem_we        = 1'b1;
        mem_waddr     = e_r.prv;
        mem_wdata     = rd;
        mem_wdata.nxt = e_r.nxt;
        mem_wdata.nok = e_r.nok;
        state_nxt     = e_r.nok ? bba_pkg::ST_DROP_NRD : ret_r;
      end

      bba_pkg::ST_DROP_NRD: begin
        mem_re    = 1'b1;
        mem_raddr = e_r.nxt;
        state_nxt = bba_pkg::ST_DROP_NW;
      end

      bba_pkg::ST_DROP_NW: begin
        mem_we        = 1'b1;
        mem_waddr     = e_r.nxt;
        mem_wdata     = rd;
        mem_wdata.prv = e_r.prv;
        mem_wdata.pok = e_r.pok;
        state_nxt     = ret_r;
      end

      // push slot s_r of order ord_r onto list li_r
      bba_pkg::ST_PUSH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = s_r;
        state_nxt = bba_pkg::ST_PUSH_W;
      end

      bba_pkg::ST_PUSH_W: begin
        mem_we          = 1'b1;
        mem_waddr       = s_r;
        mem_wdata       = rd;
        mem_wdata.order = ord_r;
        mem_wdata.free  = 1'b1;
        mem_wdata.nxt   = head_r[li_r];
        mem_wdata.nok   = hok_r[li_r];
        mem_wdata.pok   = 1'b0;
        if (hok_r[li_r]) begin
          state_nxt = bba_pkg::ST_PUSH_HRD;
        end else begin
          head_nxt[li_r] = s_r;
          hok_nxt[li_r]  = 1'b1;
          state_nxt      = ret_r;
        end
      end

      bba_pkg::ST_PUSH_HRD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r[li_r];
        state_nxt = bba_pkg::ST_PUSH_HW;
      end

      bba_pkg::ST_PUSH_HW: begin
        mem_we         = 1'b1;
        mem_waddr      = head_r[li_r];
        mem_wdata      = rd;
        mem_wdata.prv  = s_r;
        mem_wdata.pok  = 1'b1;
        head_nxt[li_r] = s_r;
        hok_nxt[li_r]  = 1'b1;
        state_nxt      = ret_r;
      end

      // split down, one upper half per pass
      bba_pkg::ST_SPLIT: begin
        if (c_r > CW'(t_r)) begin
          c_nxt     = c_dec;
          li_nxt    = OW'(c_dec);
          s_nxt     = cur_r | (SW'(1) << c_dec_ord);
          ord_nxt   = lo_r + c_dec_ord;
          ret_nxt   = bba_pkg::ST_SPLIT;
          state_nxt = bba_pkg::ST_PUSH_RD;
        end else begin
          state_nxt = bba_pkg::ST_FIN_RD;
        end
      end

      bba_pkg::ST_FIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur_r;
        state_nxt = bba_pkg::ST_FIN_W;
      end

      bba_pkg::ST_FIN_W: begin
        mem_we          = 1'b1;
        mem_waddr       = cur_r;
        mem_wdata       = rd;
        mem_wdata.order = lo_r + t_r;
        mem_wdata.free  = 1'b0;
        res_nxt.ok      = 1'b1;
        res_nxt.address = (OFF_W'(cur_r) << lo_r) + OFF_W'(hdr_r);
        state_nxt       = bba_pkg::ST_DONE;
      end

      // free: range and alignment checks
      bba_pkg::ST_FREE_CHK: begin
        if (free_bad) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          cur_nxt   = SW'(off >> lo_r);
          state_nxt = bba_pkg::ST_FREE_RD;
        end
      end

      bba_pkg::ST_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur_r;
        state_nxt = bba_pkg::ST_FREE_EV;
      end

      bba_pkg::ST_FREE_EV: begin
        if (rd.order < lo_r || rd.order > hi_r) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = cur_r;
          mem_wdata      = rd;
          mem_wdata.free = 1'b1;
          ord_nxt        = rd.order;
          res_nxt.ok     = 1'b1;
          state_nxt      = bba_pkg::ST_MERGE;
        end
      end

      // merge with the buddy while it is free and of equal order
      bba_pkg::ST_MERGE: begin
        li_nxt = OW'(ord_lo);
        if (ord_r < hi_r) begin
          s_nxt     = cur_r ^ ord_bit;
          mem_re    = 1'b1;
          mem_raddr = cur_r ^ ord_bit;
          state_nxt = bba_pkg::ST_MERGE_EV;
        end else begin
          s_nxt     = cur_r;
          ret_nxt   = bba_pkg::ST_DONE;
          state_nxt = bba_pkg::ST_PUSH_RD;
        end
      end

      bba_pkg::ST_MERGE_EV: begin
        if (!rd.free || rd.order != ord_r) begin
          s_nxt     = cur_r;
          ret_nxt   = bba_pkg::ST_DONE;
          state_nxt = bba_pkg::ST_PUSH_RD;
        end else begin
          ret_nxt   = bba_pkg::ST_MERGE_UP;
          state_nxt = bba_pkg::ST_DROP_RD;
        end
      end

      bba_pkg::ST_MERGE_UP: begin
        cur_nxt   = cur_up;
        ord_nxt   = ord_r + ORD_W'(1);
        mem_re    = 1'b1;
        mem_raddr = cur_up;
        state_nxt = bba_pkg::ST_MERGE_W;
      end

      bba_pkg::ST_MERGE_W: begin
        mem_we          = 1'b1;
        mem_waddr       = cur_r;
        mem_wdata       = rd;
        mem_wdata.order = ord_r;
        state_nxt       = bba_pkg::ST_MERGE;
      end

      bba_pkg::ST_DONE: begin
        if (res_take) state_nxt = bba_pkg::ST_IDLE;
      end

      default: state_nxt = bba_pkg::ST_IDLE;
    endcase
  end

  assign res_valid = (state_r == bba_pkg::ST_DONE);
  assign res       = res_r;

  // checks
  `BBA_ASSERT_NOW(a_no_rw_overlap, mem_we, !mem_re)
  `BBA_ASSERT_NEXT(a_done_to_idle, res_valid && res_take, state_r == bba_pkg::ST_IDLE)
  `BBA_ASSERT_NOW(a_push_head_link, state_r == bba_pkg::ST_PUSH_W, mem_we && !mem_wdata.pok)

endmodule

>>> hdl/buddy_block_allocator.sv
// buddy block allocator top level: streams, config registers, result register
// Steps to out_tvalid: init pushes the pool as one free block (not on a bad setting);
//   allocate rounds the size, scans orders up to the first non-empty list, unlinks and
//   splits; free checks, merges with free buddies and pushes; refused or unknown items
//   go to the result after any scan. Throughput: one item at a time, set by the sequencer
//   walking the slot memory one access per cycle; a held result adds its stall.
// Reset clears control state and list valid bits and restores config defaults;
//   the slot memory is not cleared and no pool is active until an init item.
`include "assert_macros.svh"

module buddy_block_allocator #(
  parameter int ORDER_COUNT = 16,
  parameter int SLOT_COUNT  = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,  // request_bytes, payload_offset
  input  logic [bba_pkg::CMD_W-1:0]       in_tuser,  // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata, // address
  output logic                            out_tuser, // ok
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::HDR_W-1:0]       cfg_data
);

  logic [bba_pkg::ORD_W-1:0] pool_r, min_r;
  logic [bba_pkg::HDR_W-1:0] hdr_r;
  bba_pkg::cmd_t             cmd;
  bba_pkg::res_t             res, out_res_r;
  logic                      res_valid, res_take, out_valid_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= 5'd16;
      min_r  <= 5'd5;
      hdr_r  <= 7'd24;
    end else if (cfg_valid) begin
      if (cfg_index == bba_pkg::REG_POOL_ORDER) pool_r <= cfg_data[bba_pkg::ORD_W-1:0];
      if (cfg_index == bba_pkg::REG_MIN_ORDER)  min_r  <= cfg_data[bba_pkg::ORD_W-1:0];
      if (cfg_index == bba_pkg::REG_HDR_BYTES)  hdr_r  <= cfg_data;
    end
  end

  // input unpacking
  assign cmd.command        = in_tuser;
  assign cmd.request_bytes  = in_tdata[20:0];
  assign cmd.payload_offset = in_tdata[40:21];

  bba_seq #(.ORDER_COUNT(ORDER_COUNT), .SLOT_COUNT(SLOT_COUNT)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .cfg_pool  (pool_r),
    .cfg_min   (min_r),
    .cfg_hdr   (hdr_r)
  );

  // result register
  assign res_take = res_valid && (!out_valid_r || out_tready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ok;
  assign out_tdata  = {4'd0, out_res_r.address};

  // an accepted item closes the input in the next cycle
  `BBA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule
